### rtl/core/dlpe_pkg.sv
// Shared types and constants of the line program encoder.
`default_nettype none
package dlpe_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] OP_COPY        = 8'h01;
    localparam logic [7:0] OP_ADVANCE_PC  = 8'h02;
    localparam logic [7:0] OP_ADVANCE_LN  = 8'h03;
    localparam logic [7:0] OP_SET_FILE    = 8'h04;
    localparam logic [7:0] OP_SET_COLUMN  = 8'h05;

    localparam logic [6:0] LEB_MASK = 7'h7f;
    localparam logic [7:0] LEB_MORE = 8'h80;

    typedef struct packed {
        logic [31:0] code_offset;
        logic [15:0] file_index;
        logic [31:0] line_number;
        logic [15:0] column_number;
    } dlpe_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } dlpe_out_t;

    typedef struct packed {
        logic        has_pc;
        logic        has_col;
        logic [31:0] pc_delta;
        logic [15:0] file;
        logic [32:0] line_delta;
        logic [15:0] col;
    } dlpe_cmd_t;

endpackage
`default_nettype wire

### rtl/core/dwarf_line_program_encoder.sv
// Top level of the line number program encoder.
//
//  channel | direction | payload     | handshake
//  in      | input     | dlpe_in_t   | in_valid / in_ready
//  out     | output    | dlpe_out_t  | out_valid / out_ready
//
// One output byte per cycle while out_ready is high; a record gives a run of
// 5 to 21 bytes, set by the byte serializer of the back end.
// Records enter at one per cycle until the four-entry command queue fills.
// Reset clears the previous offset to 0 and the previous line to 1.
// Each side stalls on its own; the output register holds a byte until taken.
`default_nettype none
module dwarf_line_program_encoder
    import dlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dlpe_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dlpe_out_t      out_data
);

    logic      push;
    dlpe_cmd_t push_cmd;
    logic      pop;
    dlpe_cmd_t head;
    logic      q_empty;
    logic      q_full;

    dlpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    dlpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dlpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

### rtl/core/dlpe_front.sv
// Front end: takes records, forms deltas, tracks previous offset and line.
`default_nettype none
module dlpe_front
    import dlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dlpe_in_t  in_data,
    output logic           push,
    output dlpe_cmd_t      push_cmd,
    input  wire logic      q_full
);

    logic [31:0] base_offset_reg;
    logic [31:0] base_line_reg;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_cmd.has_pc     = in_data.code_offset > base_offset_reg;
        push_cmd.has_col    = in_data.column_number != 16'd0;
        push_cmd.pc_delta   = in_data.code_offset - base_offset_reg;
        push_cmd.file       = in_data.file_index;
        push_cmd.line_delta = {1'b0, in_data.line_number} - {1'b0, base_line_reg};
        push_cmd.col        = in_data.column_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= 32'd0;
            base_line_reg   <= 32'd1;
        end
        else if (push)
        begin
            base_offset_reg <= in_data.code_offset;
            base_line_reg   <= in_data.line_number;
        end
    end

endmodule
`default_nettype wire

### rtl/core/dlpe_queue.sv
// Small command queue between front and back end.
`default_nettype none
module dlpe_queue
    import dlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dlpe_cmd_t push_cmd,
    input  wire logic      pop,
    output dlpe_cmd_t      head,
    output logic           empty,
    output logic           full
);

    dlpe_cmd_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign empty = count_reg == QCNT_W'(0);
    assign full  = count_reg == QCNT_W'(QDEPTH);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/dlpe_back.sv
// Back end: serializes opcodes and LEB128 operands, one byte per cycle while the output is not stalled.
`default_nettype none
module dlpe_back
    import dlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dlpe_cmd_t head,
    input  wire logic      q_empty,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dlpe_out_t      out_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PC_OP   = 4'd1;
    localparam logic [3:0] ST_PC_DAT  = 4'd2;
    localparam logic [3:0] ST_FL_OP   = 4'd3;
    localparam logic [3:0] ST_FL_DAT  = 4'd4;
    localparam logic [3:0] ST_LN_OP   = 4'd5;
    localparam logic [3:0] ST_LN_DAT  = 4'd6;
    localparam logic [3:0] ST_CL_OP   = 4'd7;
    localparam logic [3:0] ST_CL_DAT  = 4'd8;
    localparam logic [3:0] ST_COPY    = 4'd9;

    logic [3:0]  state_reg, state_next;
    dlpe_cmd_t   cmd_reg, cmd_next;
    logic [32:0] work_reg, work_next;
    logic        sgn_reg, sgn_next;
    logic        out_valid_reg, out_valid_next;
    dlpe_out_t   out_reg, out_next;

    logic        advance;
    logic        emit;
    dlpe_out_t   emit_data;
    logic [32:0] shifted;
    logic        more;
    logic [7:0]  leb_byte;

    assign advance   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        shifted = {(sgn_reg ? {7{work_reg[32]}} : 7'd0), work_reg[32:7]};
        if (sgn_reg)
            more = !((shifted == 33'd0 && !work_reg[6]) || (&shifted && work_reg[6]));
        else
            more = shifted != 33'd0;
        leb_byte = {1'b0, work_reg[6:0] & LEB_MASK} | (more ? LEB_MORE : 8'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        work_next  = work_reg;
        sgn_next   = sgn_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_data  = '0;
        if (advance)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pop        = 1'b1;
                        cmd_next   = head;
                        state_next = head.has_pc ? ST_PC_OP : ST_FL_OP;
                    end
                end
                ST_PC_OP:
                begin
                    emit               = 1'b1;
                    emit_data.out_byte = OP_ADVANCE_PC;
                    work_next          = {1'b0, cmd_reg.pc_delta};
                    sgn_next           = 1'b0;
                    state_next         = ST_PC_DAT;
                end
                ST_FL_OP:
                begin
                    emit               = 1'b1;
                    emit_data.out_byte = OP_SET_FILE;
                    work_next          = {17'd0, cmd_reg.file};
                    sgn_next           = 1'b0;
                    state_next         = ST_FL_DAT;
                end
                ST_LN_OP:
                begin
                    emit               = 1'b1;
                    emit_data.out_byte = OP_ADVANCE_LN;
                    work_next          = cmd_reg.line_delta;
                    sgn_next           = 1'b1;
                    state_next         = ST_LN_DAT;
                end
                ST_CL_OP:
                begin
                    emit               = 1'b1;
                    emit_data.out_byte = OP_SET_COLUMN;
                    work_next          = {17'd0, cmd_reg.col};
                    sgn_next           = 1'b0;
                    state_next         = ST_CL_DAT;
                end
                ST_PC_DAT, ST_FL_DAT, ST_LN_DAT, ST_CL_DAT:
                begin
                    emit               = 1'b1;
                    emit_data.out_byte = leb_byte;
                    work_next          = shifted;
                    if (!more)
                    begin
                        case (state_reg)
                            ST_PC_DAT: state_next = ST_FL_OP;
                            ST_FL_DAT: state_next = ST_LN_OP;
                            ST_LN_DAT: state_next = cmd_reg.has_col ? ST_CL_OP : ST_COPY;
                            default:   state_next = ST_COPY;
                        endcase
                    end
                end
                ST_COPY:
                begin
                    emit                  = 1'b1;
                    emit_data.out_byte    = OP_COPY;
                    emit_data.last_of_run = 1'b1;
                    if (!q_empty)
                    begin
                        pop        = 1'b1;
                        cmd_next   = head;
                        state_next = head.has_pc ? ST_PC_OP : ST_FL_OP;
                    end
                    else
                        state_next = ST_IDLE;
                end
                default:
                    state_next = ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = emit;
            out_next       = emit_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        work_reg <= work_next;
        sgn_reg  <= sgn_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for dwarf_line_program_encoder: location records in, byte runs checked in order.
module tb;
    import dlpe_pkg::*;

    localparam int CLK_HALF  = 4;
    localparam int MAX_SHOWN = 10;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_WAIT = 30;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_PATTERN} ready_mode_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    dlpe_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    dlpe_out_t out_data;

    dlpe_out_t   pending_bytes[$];
    logic [31:0] exp_offset  = 32'd0;
    logic [31:0] exp_line    = 32'd1;
    logic [31:0] stim_offset = 32'd0;
    logic [31:0] stim_line   = 32'd1;

    int          mismatches    = 0;
    int          records_sent  = 0;
    int          bytes_checked = 0;
    int          runs_checked  = 0;
    int          longest_run   = 0;
    int          backward_lines = 0;
    int          gap_max       = 0;
    int          burst_left    = 0;
    int          stall_cycles  = 0;
    int          cycle_no      = 0;
    ready_mode_t ready_mode    = READY_ALWAYS;

    dwarf_line_program_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Expected byte runs
    function automatic void push_byte(input logic [7:0] b, input logic last);
        dlpe_out_t e;
        e.out_byte    = b;
        e.last_of_run = last;
        pending_bytes.push_back(e);
    endfunction

    function automatic void push_uleb(input logic [31:0] v);
        logic [31:0] rest;
        logic [7:0]  b;
        rest = v;
        do
        begin
            b    = {1'b0, rest[6:0] & LEB_MASK};
            rest = rest >> 7;
            if (rest != 0)
                b = b | LEB_MORE;
            push_byte(b, 1'b0);
        end
        while (rest != 0);
    endfunction

    function automatic void push_sleb(input logic signed [32:0] v);
        logic signed [32:0] rest;
        logic [7:0]         b;
        bit                 done;
        rest = v;
        done = 1'b0;
        while (!done)
        begin
            b    = {1'b0, rest[6:0] & LEB_MASK};
            rest = rest >>> 7;
            if ((rest == 0 && !b[6]) || (rest == '1 && b[6]))
                done = 1'b1;
            else
                b = b | LEB_MORE;
            push_byte(b, 1'b0);
        end
    endfunction

    function automatic void encode_location(input dlpe_in_t rec);
        logic signed [32:0] line_step;
        int                 first;
        first = pending_bytes.size();
        if (rec.code_offset > exp_offset)
        begin
            push_byte(OP_ADVANCE_PC, 1'b0);
            push_uleb(rec.code_offset - exp_offset);
        end
        push_byte(OP_SET_FILE, 1'b0);
        push_uleb({16'd0, rec.file_index});
        // 33-bit wrap of the difference is the exact signed delta
        line_step = {1'b0, rec.line_number} - {1'b0, exp_line};
        if (line_step < 0)
            backward_lines++;
        push_byte(OP_ADVANCE_LN, 1'b0);
        push_sleb(line_step);
        if (rec.column_number != 0)
        begin
            push_byte(OP_SET_COLUMN, 1'b0);
            push_uleb({16'd0, rec.column_number});
        end
        push_byte(OP_COPY, 1'b1);
        if (pending_bytes.size() - first > longest_run)
            longest_run = pending_bytes.size() - first;
        exp_offset = rec.code_offset;
        exp_line   = rec.line_number;
    endfunction

    // Input side: bursts with random gaps when gap_max is nonzero
    task automatic send_record(input dlpe_in_t rec);
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge clk);
                burst_left = $urandom_range(12, 1);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data  <= rec;
        do
            @(posedge clk);
        while (!in_ready);
        encode_location(rec);
        records_sent++;
        stim_offset = rec.code_offset;
        stim_line   = rec.line_number;
    endtask

    function automatic dlpe_in_t make_record(input logic [31:0] offset, input logic [15:0] file,
                                             input logic [31:0] line, input logic [15:0] column);
        dlpe_in_t r;
        r.code_offset   = offset;
        r.file_index    = file;
        r.line_number   = line;
        r.column_number = column;
        return r;
    endfunction

    function automatic dlpe_in_t random_record();
        dlpe_in_t    r;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 60)
            r.code_offset = stim_offset + $urandom_range(64, 1);
        else if (pick < 72)
            r.code_offset = stim_offset + $urandom;
        else if (pick < 82)
            r.code_offset = stim_offset;
        else
            r.code_offset = $urandom;
        pick = $urandom_range(99, 0);
        if (pick < 50)
            r.file_index = 16'($urandom_range(8, 0));
        else if (pick < 80)
            r.file_index = 16'($urandom_range(300, 0));
        else
            r.file_index = 16'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 55)
            r.line_number = stim_line + 32'($urandom_range(60, 0)) - 32'd20;
        else if (pick < 65)
            r.line_number = stim_line;
        else if (pick < 80)
            r.line_number = stim_line + 32'($urandom_range(20000, 0)) - 32'd10000;
        else
            r.line_number = $urandom;
        pick = $urandom_range(99, 0);
        if (pick < 25)
            r.column_number = 16'd0;
        else if (pick < 75)
            r.column_number = 16'($urandom_range(120, 1));
        else
            r.column_number = 16'($urandom);
        return r;
    endfunction

    // Output side
    always @(posedge clk)
    begin
        cycle_no++;
        if (stall_cycles > 0)
        begin
            stall_cycles--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_HALF:   out_ready <= ($urandom_range(1, 0) == 1);
                READY_MOSTLY: out_ready <= ($urandom_range(7, 0) != 0);
                default:      out_ready <= ((cycle_no % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        dlpe_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected transfer: byte %02h last %0b, nothing pending",
                             out_data.out_byte, out_data.last_of_run);
            end
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (want.last_of_run)
                    runs_checked++;
                if (out_data.out_byte !== want.out_byte ||
                    out_data.last_of_run !== want.last_of_run)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch at byte %0d: expected %02h last %0b, got %02h last %0b",
                                 bytes_checked, want.out_byte, want.last_of_run,
                                 out_data.out_byte, out_data.last_of_run);
                end
            end
        end
    end

    // Tests
    task automatic test_reset_state();
        send_record(make_record(32'd0, 16'd0, 32'd1, 16'd0));
        send_record(make_record(32'd0, 16'd1, 32'd1, 16'd1));
    endtask

    task automatic test_field_extremes();
        send_record(make_record(32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff));
        send_record(make_record(32'd0, 16'd0, 32'd0, 16'd0));
        send_record(make_record(32'hffff_ffff, 16'h8000, 32'hffff_ffff, 16'h0001));
        send_record(make_record(32'hffff_fffe, 16'h7fff, 32'h0000_0001, 16'h8000));
        send_record(make_record(32'd1, 16'd0, 32'h8000_0000, 16'h7fff));
    endtask

    task automatic test_leb_boundaries();
        int unsigned pc_steps[6]   = '{127, 128, 16383, 16384, 2097152, 268435456};
        int          line_steps[8] = '{63, 64, -64, -65, 8191, 8192, -8192, -8193};
        logic [15:0] word_vals[8]  = '{16'd127, 16'd128, 16'd16383, 16'd16384,
                                       16'd1, 16'd65535, 16'd255, 16'd256};
        send_record(make_record(32'd100, 16'd2, 32'd100000, 16'd0));
        for (int i = 0; i < 8; i++)
            send_record(make_record(stim_offset + pc_steps[i % 6], word_vals[i],
                                    stim_line + 32'(line_steps[i]), word_vals[7 - i]));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(3, 0));
                gap_max    = $urandom_range(6, 0);
                burst_left = 0;
            end
            send_record(random_record());
        end
    endtask

    task automatic test_backpressure();
        gap_max      = 0;
        stall_cycles = HOLD_LEN;
        for (int i = 0; i < 16; i++)
            send_record(random_record());
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        ready_mode = READY_MOSTLY;
        gap_max    = 3;
        test_reset_state();
        test_field_extremes();
        test_leb_boundaries();
        test_random_traffic(120);
        test_backpressure();
        test_random_traffic(130);
        drain_outputs();
        $display("%0d records sent, %0d runs and %0d bytes checked, longest run %0d bytes",
                 records_sent, runs_checked, bytes_checked, longest_run);
        $display("%0d backward line steps, one %0d-cycle output hold, mixed bursts and stalls",
                 backward_lines, HOLD_LEN);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
